// ===== sv/rtti_pkg.sv =====
// rtti_pkg: shared types, constants and the digit decoder of the
// radix text to integer unit. No dependencies.
package rtti_pkg;

  localparam int unsigned TextW  = 8;
  localparam int unsigned RadixW = 7;
  localparam int unsigned NumW   = 64;
  localparam int unsigned DigitW = 6;
  localparam int unsigned ProdW  = NumW + RadixW;

  localparam logic [RadixW-1:0] RadixReset    = 7'd10;
  localparam logic [RadixW-1:0] RadixMin      = 7'd2;
  localparam logic [RadixW-1:0] RadixMax      = 7'd64;
  localparam logic [RadixW-1:0] RadixAlnumMax = 7'd36;
  localparam logic [RadixW-1:0] RadixNoCase   = 7'd38;

  localparam logic [TextW-1:0] ChDot   = 8'h2e;
  localparam logic [TextW-1:0] ChSlash = 8'h2f;
  localparam logic [TextW-1:0] Ch0     = 8'h30;
  localparam logic [TextW-1:0] Ch9     = 8'h39;
  localparam logic [TextW-1:0] ChUpA   = 8'h41;
  localparam logic [TextW-1:0] ChUpZ   = 8'h5a;
  localparam logic [TextW-1:0] ChLoA   = 8'h61;
  localparam logic [TextW-1:0] ChLoZ   = 8'h7a;
  localparam logic [TextW-1:0] ChNul   = 8'h00;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_INVALID  = 2'd1,
    FAULT_OVERFLOW = 2'd2
  } fault_e;

  typedef struct packed {
    logic [TextW-1:0] text_byte;
    logic             final_byte;
  } item_t;

  typedef struct packed {
    logic [NumW-1:0] number;
    logic            invalid;
    logic            overflowed;
  } result_t;

  typedef struct packed {
    logic              ok;
    logic [DigitW-1:0] value;
  } digit_t;

  // decode one character into its digit value for base b
  function automatic digit_t digit_value(logic [TextW-1:0] ch, logic [RadixW-1:0] b);
    logic [RadixW-1:0] v;
    logic              hit;
    logic              wide;
    digit_t            d;
    wide = (b > RadixAlnumMax);
    hit  = 1'b1;
    v    = '0;
    if (ch inside {[Ch0:Ch9]}) begin
      v = RadixW'(ch - Ch0);
    end else if (ch inside {[ChUpA:ChUpZ]}) begin
      v = RadixW'(ch - ChUpA) + 7'd10;
    end else if (ch inside {[ChLoA:ChLoZ]}) begin
      v = (b <= RadixNoCase) ? RadixW'(ch - ChLoA) + 7'd10 : RadixW'(ch - ChLoA) + 7'd36;
    end else if (ch == ChDot || ch == ChSlash) begin
      hit = wide;
      v   = RadixW'(ch - ChDot);
    end else begin
      hit = 1'b0;
    end
    // above base 36 the two symbols come first, so shift everything else up
    if (wide && ch != ChDot && ch != ChSlash) begin
      v = v + 7'd2;
    end
    d.ok    = hit && (v < b);
    d.value = v[DigitW-1:0];
    return d;
  endfunction

endpackage

// ===== sv/rtti_in_if.sv =====
// rtti_in_if: character channel of the radix text to integer unit.
// Depends on rtti_pkg.
interface rtti_in_if import rtti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TextW-1:0] text_byte;
  logic             final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink (input valid, text_byte, final_byte, output ready);
endinterface

// ===== sv/rtti_out_if.sv =====
// rtti_out_if: result channel of the radix text to integer unit.
// Depends on rtti_pkg.
interface rtti_out_if import rtti_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [NumW-1:0] number;
  logic            invalid;
  logic            overflowed;

  modport source (output valid, number, invalid, overflowed, input ready);
  modport sink (input valid, number, invalid, overflowed, output ready);
endinterface

// ===== sv/radix_text_to_integer_unit.sv =====
// radix_text_to_integer_unit: top level of the radix text to integer unit.
// Depends on rtti_pkg, rtti_in_if, rtti_out_if, rtti_in_reg, rtti_accum
// and rtti_out_reg.
//
// usage
// - text_i carries one character per transaction with a flag on the last one
// - result_o carries one transaction per string: number, invalid, overflowed
// - the base is written through cfg_we_i/cfg_wdata_i while the unit is idle
// - throughput: one character per cycle unless a final one waits for the result
//   slot; the 64 by 7 bit multiply-accumulate between input register and
//   accumulator is the one pass each character takes
// - a final character's result is shown on result_o from the output register
// - a stalled receiver holds the result in the output register; characters
//   that are not final keep flowing, a final one waits in the input register
//   until the result slot frees
// - reset clears the accumulator, the fault state and both valid flags and
//   sets the base to 10
module radix_text_to_integer_unit import rtti_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RadixW-1:0] cfg_wdata_i,
  rtti_in_if.sink           text_i,
  rtti_out_if.source        result_o
);

  item_t   in_item, s1_item;
  logic    s1_valid;
  logic    advance;
  logic    load;
  logic    out_free;
  result_t acc_result, out_result;

  assign in_item.text_byte  = text_i.text_byte;
  assign in_item.final_byte = text_i.final_byte;

  rtti_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (text_i.valid),
    .in_ready_o (text_i.ready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  rtti_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .load_o      (load),
    .result_o    (acc_result)
  );

  rtti_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (acc_result),
    .free_o      (out_free),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .result_o    (out_result)
  );

  assign result_o.number     = out_result.number;
  assign result_o.invalid    = out_result.invalid;
  assign result_o.overflowed = out_result.overflowed;

endmodule

// ===== sv/rtti_in_reg.sv =====
// rtti_in_reg: input register holding one character transaction.
// Depends on rtti_pkg.
module rtti_in_reg import rtti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take ? 1'b1 : (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/rtti_accum.sv =====
// rtti_accum: radix register, digit decode and the multiply-accumulate
// with sticky fault tracking. Depends on rtti_pkg.
module rtti_accum import rtti_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RadixW-1:0] cfg_wdata_i,
  input  logic              valid_i,
  input  item_t             item_i,
  input  logic              out_free_i,
  output logic              advance_o,
  output logic              load_o,
  output result_t           result_o
);

  logic [RadixW-1:0] radix_q;
  logic [NumW-1:0]   acc_q, acc_d, acc_new;
  fault_e            fault_q, fault_d, fault_new;
  digit_t            dig;
  logic              base_bad;
  logic [ProdW-1:0]  prod;
  logic [NumW:0]     sum;
  logic              ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  assign dig      = digit_value(item_i.text_byte, radix_q);
  assign base_bad = (radix_q < RadixMin) || (radix_q > RadixMax);
  assign prod     = {{RadixW{1'b0}}, acc_q} * {{NumW{1'b0}}, radix_q};
  assign sum      = {1'b0, prod[NumW-1:0]} + {{(NumW+1-DigitW){1'b0}}, dig.value};
  assign ovf      = (|prod[ProdW-1:NumW]) || sum[NumW];

  // final transactions wait for a free result slot, others never stall
  assign advance_o = valid_i && (!item_i.final_byte || out_free_i);
  assign load_o    = advance_o && item_i.final_byte;

  always_comb begin
    acc_new   = acc_q;
    fault_new = fault_q;
    case (fault_q)
      FAULT_NONE: begin
        if (base_bad || item_i.text_byte == ChNul || !dig.ok) begin
          fault_new = FAULT_INVALID;
        end else if (ovf) begin
          fault_new = FAULT_OVERFLOW;
        end else begin
          acc_new = sum[NumW-1:0];
        end
      end
      default: begin
        fault_new = fault_q;
      end
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    fault_d = fault_q;
    if (advance_o) begin
      if (item_i.final_byte) begin
        acc_d   = '0;
        fault_d = FAULT_NONE;
      end else begin
        acc_d   = acc_new;
        fault_d = fault_new;
      end
    end
  end

  assign result_o.number     = (fault_new == FAULT_NONE) ? acc_new : '0;
  assign result_o.invalid    = (fault_new == FAULT_INVALID);
  assign result_o.overflowed = (fault_new == FAULT_OVERFLOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      fault_q <= FAULT_NONE;
    end else begin
      acc_q   <= acc_d;
      fault_q <= fault_d;
    end
  end

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> (acc_q == '0) && (fault_q == FAULT_NONE))
    else $error("state not cleared after final transaction");

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q != FAULT_NONE) && !load_o |=> fault_q == $past(fault_q))
    else $error("fault changed within a string");

  a_acc_frozen_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q != FAULT_NONE) && !load_o |=> $stable(acc_q))
    else $error("accumulator moved after a fault");

endmodule

// ===== sv/rtti_out_reg.sv =====
// rtti_out_reg: result register that holds one finished transaction while
// the receiver stalls. Depends on rtti_pkg.
module rtti_out_reg import rtti_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

  a_one_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(res_q.invalid && res_q.overflowed))
    else $error("both fault flags set");

  a_zero_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (res_q.invalid || res_q.overflowed) |-> res_q.number == '0)
    else $error("nonzero number with a fault");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !valid_q || out_ready_i)
    else $error("result loaded over a pending transaction");

endmodule

// ===== sim/radix_text_to_integer_unit_test.sv =====
// radix_text_to_integer_unit_test: self-checking testbench of the radix text to integer unit.
// Depends on rtti_pkg, rtti_in_if, rtti_out_if and radix_text_to_integer_unit.
// Characters go in with random gaps and stalls, each result is checked against a local parser.
module radix_text_to_integer_unit_test;
  import rtti_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NoDigit   = 255;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned RandItems = 1300;

  typedef logic [TextW-1:0] text_q_t [$];

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [RadixW-1:0] cfg_wdata = RadixReset;

  rtti_in_if  text_if ();
  rtti_out_if result_if ();

  radix_text_to_integer_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .text_i      (text_if),
    .result_o    (result_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser state kept alongside the unit
  logic [RadixW-1:0] radix_shadow = RadixReset;
  logic [NumW-1:0]   acc_shadow = '0;
  fault_e            fault_shadow = FAULT_NONE;
  result_t           expected_parses [$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  bit          text_idle = 1'b1;
  bit          result_idle = 1'b1;
  bit          hold_req = 1'b0;

  // digit value of a character in a base, NoDigit if it is none
  function automatic int unsigned digit_of(logic [TextW-1:0] ch, int unsigned base);
    int unsigned v;
    if (ch >= Ch0 && ch <= Ch9) begin
      v = 32'(ch - Ch0);
    end else if (ch >= ChUpA && ch <= ChUpZ) begin
      v = 32'(ch - ChUpA) + 10;
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      v = (base <= RadixNoCase) ? 32'(ch - ChLoA) + 10 : 32'(ch - ChLoA) + 36;
    end else if ((ch == ChDot || ch == ChSlash) && base > RadixAlnumMax) begin
      return 32'(ch - ChDot);
    end else begin
      return NoDigit;
    end
    if (base > RadixAlnumMax) v += 2;
    return (v < base) ? v : NoDigit;
  endfunction

  // character for a digit value, with a random case where case does not matter
  function automatic logic [TextW-1:0] digit_char(int unsigned v, int unsigned base);
    bit lower;
    lower = 1'($urandom_range(0, 1));
    if (base <= RadixAlnumMax) begin
      if (v < 10) return Ch0 + TextW'(v);
      return lower ? ChLoA + TextW'(v - 10) : ChUpA + TextW'(v - 10);
    end
    if (v < 2) return ChDot + TextW'(v);
    if (v < 12) return Ch0 + TextW'(v - 2);
    if (v < 38) begin
      return (lower && base <= RadixNoCase) ? ChLoA + TextW'(v - 12)
                                            : ChUpA + TextW'(v - 12);
    end
    return ChLoA + TextW'(v - 38);
  endfunction

  // digits of the largest 64-bit value in a base
  function automatic text_q_t max_value_text(int unsigned base);
    logic [NumW-1:0] val;
    text_q_t         s;
    val = '1;
    while (val != 0) begin
      s.push_front(digit_char(32'(val % base), base));
      val = val / base;
    end
    return s;
  endfunction

  function automatic void parse_char(logic [TextW-1:0] ch, logic fin);
    int unsigned     d;
    logic [71:0]     wide;
    result_t         r;
    if (fault_shadow == FAULT_NONE) begin
      if (radix_shadow < RadixMin || radix_shadow > RadixMax || ch == ChNul) begin
        fault_shadow = FAULT_INVALID;
      end else begin
        d = digit_of(ch, 32'(radix_shadow));
        if (d == NoDigit) begin
          fault_shadow = FAULT_INVALID;
        end else begin
          wide = 72'(acc_shadow) * 72'(radix_shadow) + 72'(d);
          if (wide[71:64] != '0) begin
            fault_shadow = FAULT_OVERFLOW;
          end else begin
            acc_shadow = wide[63:0];
          end
        end
      end
    end
    if (fin) begin
      r.number     = (fault_shadow == FAULT_NONE) ? acc_shadow : '0;
      r.invalid    = (fault_shadow == FAULT_INVALID);
      r.overflowed = (fault_shadow == FAULT_OVERFLOW);
      expected_parses = {expected_parses, r};
      acc_shadow   = '0;
      fault_shadow = FAULT_NONE;
    end
  endfunction

  task automatic send_char(input logic [TextW-1:0] ch, input logic fin);
    int unsigned gap;
    gap = text_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_if.valid      <= 1'b1;
    text_if.text_byte  <= ch;
    text_if.final_byte <= fin;
    do @(posedge clk); while (!text_if.ready);
    parse_char(ch, fin);
    items_sent++;
  endtask

  task automatic send_text(input text_q_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_literal(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // sender stops until every result is back, then lets the pipeline settle
  task automatic drain();
    text_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_parses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RadixW-1:0] r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_shadow = r;
    @(posedge clk);
  endtask

  function automatic logic [RadixW-1:0] pick_radix();
    logic [RadixW-1:0] corners [10] = '{7'd0, 7'd1, 7'd2, 7'd36, 7'd37, 7'd38, 7'd39,
                                         7'd64, 7'd65, 7'd127};
    int unsigned       sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return RadixW'($urandom_range(65, 127));
    if (sel < 12) return RadixW'($urandom_range(0, 1));
    if (sel < 30) return corners[$urandom_range(0, 9)];
    return RadixW'($urandom_range(2, 64));
  endfunction

  task automatic test_directed();
    text_q_t s;
    send_literal("7");
    send_literal("42");
    send_char(ChNul, 1'b1);
    send_literal("9a");
    send_char(8'hff, 1'b1);
    drain();
    write_radix(7'd2);
    send_literal("121");
    drain();
    write_radix(7'd64);
    send_literal("/.zZ");
    s = {};
    repeat (11) s = {s, ChLoZ};
    send_text(s);
    drain();
    write_radix(7'd37);
    send_literal("aA");
    drain();
    write_radix(7'd0);
    send_literal("1");
    drain();
    write_radix(7'd127);
    send_literal("1");
    drain();
  endtask

  task automatic test_random_strings();
    text_q_t     s;
    int unsigned base;
    int unsigned full_len;
    int unsigned kind;
    int unsigned len;
    while (items_sent < RandItems) begin
      write_radix(pick_radix());
      base        = radix_shadow;
      text_idle   = $urandom_range(0, 3) != 0;
      result_idle = $urandom_range(0, 3) != 0;
      if (base >= RadixMin && base <= RadixMax) begin
        s        = max_value_text(base);
        full_len = s.size();
      end else begin
        full_len = 4;
      end
      repeat ($urandom_range(5, 20)) begin
        s    = {};
        kind = $urandom_range(0, 99);
        // outside the legal bases digits are drawn as for base 64
        if (base < RadixMin || base > RadixMax) base = RadixMax;
        if (kind < 55) begin
          len = $urandom_range(1, 6);
          repeat (len) s = {s, digit_char($urandom_range(0, base - 1), base)};
        end else if (kind < 70) begin
          len = full_len + $urandom_range(0, 1);
          repeat (len) s = {s, digit_char($urandom_range(0, base - 1), base)};
        end else if (kind < 78) begin
          s = max_value_text(base);
          if ($urandom_range(0, 1)) s[s.size() - 1] = digit_char(base - 1, base);
        end else if (kind < 92) begin
          len = $urandom_range(1, 6);
          repeat (len) s = {s, digit_char($urandom_range(0, base - 1), base)};
          s.insert($urandom_range(0, len), 8'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(1, 4);
          repeat (len) s = {s, 8'($urandom_range(0, 255))};
        end
        base = radix_shadow;
        send_text(s);
      end
      drain();
    end
  endtask

  // receiver holds off while the sender keeps offering, so the unit backs up
  task automatic test_backpressure();
    text_q_t s;
    write_radix(7'd16);
    text_idle = 1'b0;
    hold_req  = 1'b1;
    @(posedge clk);
    repeat (40) begin
      s = {};
      repeat ($urandom_range(1, 3)) s = {s, digit_char($urandom_range(0, 15), 16)};
      send_text(s);
    end
    drain();
    text_idle = 1'b1;
  endtask

  // receiver: random stall after each result, plus a long hold on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left      = 0;
    hold_left       = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HoldLen;
        hold_req  = 1'b0;
      end
      if (result_if.valid && result_if.ready) begin
        stall_left = result_idle ? $urandom_range(0, 3) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      if (hold_left != 0) hold_left--;
      result_if.ready <= rst_n && stall_left == 0 && hold_left == 0;
    end
  end

  result_t want;

  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      if (expected_parses.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none pending, expected nothing, actual %h %b %b", $time,
                 result_if.number, result_if.invalid, result_if.overflowed);
      end else begin
        want = expected_parses.pop_front();
        if (result_if.number !== want.number) begin
          mismatch_count++;
          $display("%0t: number expected %h actual %h", $time, want.number, result_if.number);
        end
        if (result_if.invalid !== want.invalid) begin
          mismatch_count++;
          $display("%0t: invalid expected %b actual %b", $time, want.invalid,
                   result_if.invalid);
        end
        if (result_if.overflowed !== want.overflowed) begin
          mismatch_count++;
          $display("%0t: overflowed expected %b actual %b", $time, want.overflowed,
                   result_if.overflowed);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    text_if.valid      = 1'b0;
    text_if.text_byte  = '0;
    text_if.final_byte = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_strings();
    test_backpressure();
    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_parses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
